[rtl/nnfd_pkg.sv]
// nnfd_pkg: shared widths, register codes, reset values and result type
// for the nearest-neighbor fit downscale unit; no dependencies
`timescale 1ns / 1ps

package nnfd_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned DIV_W     = 2 * DIM_W;

  localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 13'd480;
  localparam logic [DIM_W-1:0] MAX_SIZE_RST   = 13'd256;
  localparam logic [CH_W-1:0]  CHANNELS_RST   = 3'd4;

  // channel count that keeps all four pixel bytes
  localparam logic [CH_W-1:0] CH_FULL = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_MAX_SIZE   = 2'd2,
    REG_CHANNELS   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } res_item_t;

endpackage

[rtl/nnfd_src_if.sv]
// nnfd_src_if: valid/ready channel carrying one source pixel
// depends on nnfd_pkg
`timescale 1ns / 1ps

interface nnfd_src_if;
  logic                      valid;
  logic                      ready;
  logic [nnfd_pkg::PIX_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

[rtl/nnfd_res_if.sv]
// nnfd_res_if: valid/ready channel carrying one selected pixel and frame mark
// depends on nnfd_pkg
`timescale 1ns / 1ps

interface nnfd_res_if;
  logic                      valid;
  logic                      ready;
  logic [nnfd_pkg::PIX_W-1:0] out_pixel;
  logic                      frame_last;

  modport source (output valid, output out_pixel, output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

[rtl/nnfd_div.sv]
// nnfd_div: restoring divider, one quotient bit per cycle
// standalone, no package dependency
`timescale 1ns / 1ps

module nnfd_div #(
  parameter int unsigned DW = 26,
  parameter int unsigned VW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quot_q, quot_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW-1:0]   dsr_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;

  logic [VW:0] work;
  logic [VW:0] diff;
  logic        ge;

  // shift in the next dividend bit and try a subtract
  assign work = {rem_q, quot_q[DW-1]};
  assign ge   = work >= {1'b0, dsr_q};
  assign diff = work - {1'b0, dsr_q};

  always_comb begin
    rem_d  = ge ? diff[VW-1:0] : work[VW-1:0];
    quot_d = {quot_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

[rtl/nnfd_skid.sv]
// nnfd_skid: output register plus one skid entry for the result channel
// depends on nnfd_pkg and nnfd_res_if
`timescale 1ns / 1ps

module nnfd_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  nnfd_pkg::res_item_t push_data_i,
  output logic                ready_o,
  nnfd_res_if.source          res_o
);

  nnfd_pkg::res_item_t main_q, skid_q;
  logic                main_v_q, skid_v_q;
  logic                pop;

  assign pop     = main_v_q && res_o.ready;
  assign ready_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

  assign res_o.valid      = main_v_q;
  assign res_o.out_pixel  = main_q.out_pixel;
  assign res_o.frame_last = main_q.frame_last;

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held while output register empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q)
    else $error("result pushed while skid entry occupied");

  a_stalled_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && !res_o.ready) |=> main_v_q)
    else $error("stalled result dropped");

endmodule

[rtl/nearest_neighbor_fit_downscale_unit.sv]
// nearest_neighbor_fit_downscale_unit: top level of the fit downscaler
// depends on nnfd_pkg, nnfd_src_if, nnfd_res_if, nnfd_div and nnfd_skid
`timescale 1ns / 1ps

// usage
//   src_i   : source pixels in raster order, one transfer per pixel
//   res_o   : the nearest-neighbor picks of the scaled image, frame_last on
//             the final pick of each frame
//   cfg_*   : write port for src_width, src_height, max_size, channels
// timing
//   a result is registered in the output register, or in the skid entry on
//   a stall, on the transfer of the source pixel that it copies; one source
//   pixel is taken every cycle while src_i ready is high
//   after reset and after any register write the step quotient, remainder
//   and output size are recomputed by two 26-step bit-serial dividers; src_i
//   ready stays low meanwhile (register writes are taken as usual, a write
//   during the run queues one more run)
//   an output register and a skid entry sit in front of res_o; src_i keeps
//   taking pixels into a stall and ready drops only once both are full
// reset
//   registers return to 640 x 480, max_size 256, four channels; all pixel
//   counters and the output size go to zero

module nearest_neighbor_fit_downscale_unit #(
  parameter int unsigned MAX_DIM = nnfd_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nnfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nnfd_pkg::CFG_W-1:0]     cfg_data_i,
  nnfd_src_if.sink                      src_i,
  nnfd_res_if.source                    res_o
);

  localparam int unsigned DW = nnfd_pkg::DIM_W;
  localparam int unsigned CW = $clog2(MAX_DIM);
  // a pick can run one step past the last column, up to about twice the size
  localparam int unsigned PW = CW + 2;

  typedef struct packed {
    logic [PW-1:0] pick;
    logic [DW-1:0] rem;
  } adv_t;

  // ---------------------------------------------------------------- registers
  logic [DW-1:0]             src_w_q, src_h_q, max_q;
  logic [nnfd_pkg::CH_W-1:0] chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= nnfd_pkg::SRC_WIDTH_RST;
      src_h_q <= nnfd_pkg::SRC_HEIGHT_RST;
      max_q   <= nnfd_pkg::MAX_SIZE_RST;
      chan_q  <= nnfd_pkg::CHANNELS_RST;
    end else if (cfg_we_i) begin
      case (nnfd_pkg::cfg_reg_e'(cfg_idx_i))
        nnfd_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data_i[DW-1:0];
        nnfd_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data_i[DW-1:0];
        nnfd_pkg::REG_MAX_SIZE:   max_q   <= cfg_data_i[DW-1:0];
        nnfd_pkg::REG_CHANNELS:   chan_q  <= cfg_data_i[nnfd_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- geometry
  logic          w_gt_h;
  logic [DW-1:0] big, short_side;
  logic          geo_ok;

  assign w_gt_h     = src_w_q > src_h_q;
  assign big        = w_gt_h ? src_w_q : src_h_q;
  assign short_side = w_gt_h ? src_h_q : src_w_q;
  assign geo_ok = (src_w_q != '0) && (src_h_q != '0) && (max_q != '0) &&
                  (32'(src_w_q) <= MAX_DIM) && (32'(src_h_q) <= MAX_DIM);

  // ---------------------------------------------------------------- dividers
  // step = big / max_size, smaller output side = short side * max_size / big
  logic                          calc_pend_q;
  logic                          div_start;
  logic                          busy_step, busy_side;
  logic                          div_busy;
  logic [nnfd_pkg::DIV_W-1:0]    side_prod;
  logic [nnfd_pkg::DIV_W-1:0]    quot_step, quot_side;
  logic [DW-1:0]                 rem_step, rem_side;

  assign div_busy  = busy_step || busy_side;
  assign div_start = calc_pend_q && !div_busy;
  assign side_prod = short_side * max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_pend_q <= 1'b1;
    end else if (cfg_we_i) begin
      calc_pend_q <= 1'b1;
    end else if (div_start) begin
      calc_pend_q <= 1'b0;
    end
  end

  nnfd_div #(.DW(nnfd_pkg::DIV_W), .VW(DW)) u_div_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nnfd_pkg::DIV_W'(big)),
    .divisor_i  (max_q),
    .busy_o     (busy_step),
    .quot_o     (quot_step),
    .rem_o      (rem_step)
  );

  nnfd_div #(.DW(nnfd_pkg::DIV_W), .VW(DW)) u_div_side (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (side_prod),
    .divisor_i  (big),
    .busy_o     (busy_side),
    .quot_o     (quot_side),
    .rem_o      (rem_side)
  );

  logic [DW-1:0] step_q, step_r;
  logic [DW-1:0] stage_ow, stage_oh;
  logic          upscale;

  // quotients fit the field width whenever the geometry is valid
  assign step_q  = quot_step[DW-1:0];
  assign step_r  = rem_step;
  assign upscale = max_q > big;

  always_comb begin
    if (upscale) begin
      stage_ow = '0;
      stage_oh = '0;
    end else if (w_gt_h) begin
      stage_ow = max_q;
      stage_oh = quot_side[DW-1:0];
    end else begin
      stage_ow = quot_side[DW-1:0];
      stage_oh = max_q;
    end
  end

  // ---------------------------------------------------------------- counters
  logic [CW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [DW-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [PW-1:0] pick_col_q, pick_col_d, pick_row_q, pick_row_d;
  logic [DW-1:0] rem_col_q, rem_col_d, rem_row_q, rem_row_d;
  logic [DW-1:0] out_w_q, out_w_d, out_h_q, out_h_d;

  // quotient plus remainder stepping of one pick position
  function automatic adv_t advance(input logic [PW-1:0] pick, input logic [DW-1:0] rem,
                                   input logic [DW-1:0] q, input logic [DW-1:0] r,
                                   input logic [DW-1:0] m);
    logic [DW:0] sum;
    logic        carry;
    adv_t        res;
    sum      = {1'b0, rem} + {1'b0, r};
    carry    = sum >= {1'b0, m};
    res.rem  = carry ? DW'(sum - {1'b0, m}) : sum[DW-1:0];
    res.pick = pick + PW'(q) + PW'(carry);
    return res;
  endfunction

  logic          frame_start;
  logic [DW-1:0] ow_eff, oh_eff;
  logic          hit, col_wrap, row_wrap, row_pick;
  logic          is_last;
  logic          src_acc;
  logic          skid_rdy;
  adv_t          adv_col, adv_row;

  assign src_acc = src_i.valid && src_i.ready;
  assign src_i.ready = !calc_pend_q && !div_busy && skid_rdy;

  // output size is sampled on the first pixel of each frame
  assign frame_start = (src_col_q == '0) && (src_row_q == '0);
  assign ow_eff      = frame_start ? stage_ow : out_w_q;
  assign oh_eff      = frame_start ? stage_oh : out_h_q;

  assign hit = (out_row_q < oh_eff) && (out_col_q < ow_eff) &&
               (PW'(src_row_q) == pick_row_q) && (PW'(src_col_q) == pick_col_q);
  assign is_last = (({1'b0, out_row_q} + 1'b1) == {1'b0, oh_eff}) &&
                   (({1'b0, out_col_q} + 1'b1) == {1'b0, ow_eff});

  assign col_wrap = (({1'b0, src_col_q} + 1'b1) >= src_w_q);
  assign row_wrap = (({1'b0, src_row_q} + 1'b1) >= src_h_q);
  assign row_pick = (out_row_q < oh_eff) && (PW'(src_row_q) == pick_row_q);

  assign adv_col = advance(pick_col_q, rem_col_q, step_q, step_r, max_q);
  assign adv_row = advance(pick_row_q, rem_row_q, step_q, step_r, max_q);

  always_comb begin
    src_col_d  = src_col_q;
    src_row_d  = src_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    pick_col_d = pick_col_q;
    pick_row_d = pick_row_q;
    rem_col_d  = rem_col_q;
    rem_row_d  = rem_row_q;
    out_w_d    = ow_eff;
    out_h_d    = oh_eff;

    if (hit) begin
      out_col_d  = out_col_q + 1'b1;
      pick_col_d = adv_col.pick;
      rem_col_d  = adv_col.rem;
    end

    if (col_wrap) begin
      src_col_d = '0;
      if (row_pick) begin
        out_row_d  = out_row_q + 1'b1;
        pick_row_d = adv_row.pick;
        rem_row_d  = adv_row.rem;
      end
      out_col_d  = '0;
      pick_col_d = '0;
      rem_col_d  = '0;
      if (row_wrap) begin
        src_row_d  = '0;
        out_row_d  = '0;
        pick_row_d = '0;
        rem_row_d  = '0;
      end else begin
        src_row_d = src_row_q + 1'b1;
      end
    end else begin
      src_col_d = src_col_q + 1'b1;
    end

    // bad geometry holds everything at zero
    if (!geo_ok) begin
      src_col_d  = '0;
      src_row_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      pick_col_d = '0;
      pick_row_d = '0;
      rem_col_d  = '0;
      rem_row_d  = '0;
      out_w_d    = '0;
      out_h_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q  <= '0;
      src_row_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      pick_col_q <= '0;
      pick_row_q <= '0;
      rem_col_q  <= '0;
      rem_row_q  <= '0;
      out_w_q    <= '0;
      out_h_q    <= '0;
    end else if (src_acc) begin
      src_col_q  <= src_col_d;
      src_row_q  <= src_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      pick_col_q <= pick_col_d;
      pick_row_q <= pick_row_d;
      rem_col_q  <= rem_col_d;
      rem_row_q  <= rem_row_d;
      out_w_q    <= out_w_d;
      out_h_q    <= out_h_d;
    end
  end

  // ---------------------------------------------------------------- results
  nnfd_pkg::res_item_t push_data;
  logic                push;

  assign push = src_acc && geo_ok && hit;

  always_comb begin
    push_data.out_pixel  = src_i.src_pixel;
    push_data.frame_last = is_last;
    // any channel count other than four: upper byte forced to zero
    if (chan_q != nnfd_pkg::CH_FULL) begin
      push_data.out_pixel = {8'h00, src_i.src_pixel[23:0]};
    end
  end

  nnfd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (skid_rdy),
    .res_o       (res_o)
  );

  // ---------------------------------------------------------------- checks
  a_out_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_col_q <= out_w_q)
    else $error("output column ran past the output width");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !src_i.ready)
    else $error("pixel taken before derived values were recomputed");

  a_bad_geo_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_acc && !geo_ok) |=> (out_w_q == '0 && out_h_q == '0 && src_col_q == '0))
    else $error("state not cleared on invalid geometry");

endmodule

[tb/sv/tb_nearest_neighbor_fit_downscale_unit.sv]
// tb_nearest_neighbor_fit_downscale_unit: self-checking bench for the fit downscaler,
// streams source pixels under random stalls and checks every pick against a local scaler
// depends on nnfd_pkg, nnfd_src_if, nnfd_res_if and nearest_neighbor_fit_downscale_unit
`timescale 1ns / 1ps

module tb_nearest_neighbor_fit_downscale_unit;

  localparam int unsigned MAX_DIM    = nnfd_pkg::MAX_DIM_DEF;
  // cycles without any transfer on either channel before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // quiet cycles after the last pick before a register write or the end of the run
  localparam int unsigned PIPE_DRAIN = 8;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  nnfd_pkg::cfg_reg_e           cfg_idx;
  logic [nnfd_pkg::CFG_W-1:0]   cfg_data;

  nnfd_src_if src_ch ();
  nnfd_res_if res_ch ();

  nearest_neighbor_fit_downscale_unit #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .src_i     (src_ch),
    .res_o     (res_ch)
  );

  // local copy of the register file
  logic [nnfd_pkg::DIM_W-1:0] cfg_w;
  logic [nnfd_pkg::DIM_W-1:0] cfg_h;
  logic [nnfd_pkg::DIM_W-1:0] cfg_max;
  logic [nnfd_pkg::CH_W-1:0]  cfg_ch;

  // scaler state: source position, output position, next wanted source column/row,
  // stepping remainders and the output size latched at frame start
  int unsigned src_x, src_y;
  int unsigned dst_x, dst_y;
  int unsigned want_x, want_y;
  int unsigned frac_x, frac_y;
  int unsigned dst_w, dst_h;

  // picks still owed by the block, oldest first
  nnfd_pkg::res_item_t picks_due[$];

  // idling bounds for the sender and the receiver, changed per phase
  int unsigned idle_max  = 16;
  int unsigned stall_max = 16;

  int unsigned fail_cnt      = 0;
  int unsigned pixels_sent   = 0;
  int unsigned picks_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles  = 0;

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // scaler prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_scaler();
    src_x  = 0; src_y  = 0;
    dst_x  = 0; dst_y  = 0;
    want_x = 0; want_y = 0;
    frac_x = 0; frac_y = 0;
    dst_w  = 0; dst_h  = 0;
  endfunction

  // quotient/remainder step of floor(k * big / m) to the next k
  function automatic void step_pick(inout int unsigned want, inout int unsigned frac,
                                    input int unsigned q, input int unsigned r,
                                    input int unsigned m);
    want += q;
    frac += r;
    if (frac >= m) begin
      frac -= m;
      want++;
    end
  endfunction

  // advance the scaler by one source pixel and queue the pick it yields, if any
  function automatic void scale_pixel(input logic [nnfd_pkg::PIX_W-1:0] px);
    int unsigned         w, h, m, big, q, r;
    nnfd_pkg::res_item_t pick;
    w = cfg_w;
    h = cfg_h;
    m = cfg_max;
    // bad geometry: nothing comes out and every counter is held at zero
    if (w == 0 || h == 0 || m == 0 || w > MAX_DIM || h > MAX_DIM) begin
      clear_scaler();
      return;
    end
    big = (w > h) ? w : h;
    q   = big / m;
    r   = big % m;

    // output size is fixed at the first pixel of each frame
    if (src_x == 0 && src_y == 0) begin
      if (m > big) begin
        // upscale request gives an empty image
        dst_w = 0;
        dst_h = 0;
      end else if (w > h) begin
        dst_w = m;
        dst_h = (h * m) / w;
      end else begin
        dst_h = m;
        dst_w = (w * m) / h;
      end
    end

    if (dst_y < dst_h && dst_x < dst_w && src_y == want_y && src_x == want_x) begin
      pick.out_pixel  = (cfg_ch == nnfd_pkg::CH_FULL) ? px : {8'h00, px[23:0]};
      pick.frame_last = (dst_y + 1 == dst_h) && (dst_x + 1 == dst_w);
      picks_due.push_back(pick);
      dst_x++;
      step_pick(want_x, frac_x, q, r, m);
    end

    // raster position; row and frame wrap use the current size at once
    if (src_x + 1 >= w) begin
      src_x = 0;
      if (dst_y < dst_h && src_y == want_y) begin
        dst_y++;
        step_pick(want_y, frac_y, q, r, m);
      end
      dst_x  = 0;
      want_x = 0;
      frac_x = 0;
      if (src_y + 1 >= h) begin
        src_y  = 0;
        dst_y  = 0;
        want_y = 0;
        frac_y = 0;
      end else begin
        src_y++;
      end
    end else begin
      src_x++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one source pixel transfer after a random gap; valid stays high into the
  // next call so back-to-back pixels need no second assignment in one step
  task automatic send_pixel(input logic [nnfd_pkg::PIX_W-1:0] px);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_ch.valid     <= 1'b1;
    src_ch.src_pixel <= px;
    do @(posedge clk_i); while (!src_ch.ready);
    scale_pixel(px);
    pixels_sent++;
  endtask

  // stop sending, let every owed pick arrive, then let the pipe run dry
  task automatic wait_idle();
    src_ch.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // single register write; the extra edge keeps write enable pulses apart
  task automatic write_reg(input nnfd_pkg::cfg_reg_e idx,
                           input logic [nnfd_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      nnfd_pkg::REG_SRC_WIDTH:  cfg_w   = data;
      nnfd_pkg::REG_SRC_HEIGHT: cfg_h   = data;
      nnfd_pkg::REG_MAX_SIZE:   cfg_max = data;
      nnfd_pkg::REG_CHANNELS:   cfg_ch  = data[nnfd_pkg::CH_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [nnfd_pkg::CFG_W-1:0] w,
                              input logic [nnfd_pkg::CFG_W-1:0] h,
                              input logic [nnfd_pkg::CFG_W-1:0] m,
                              input logic [nnfd_pkg::CFG_W-1:0] ch_word);
    wait_idle();
    write_reg(nnfd_pkg::REG_SRC_WIDTH, w);
    write_reg(nnfd_pkg::REG_SRC_HEIGHT, h);
    write_reg(nnfd_pkg::REG_MAX_SIZE, m);
    write_reg(nnfd_pkg::REG_CHANNELS, ch_word);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, every transfer checked against the oldest pick
  // ---------------------------------------------------------------------------

  initial begin : result_checker
    nnfd_pkg::res_item_t want;
    int unsigned         stall;
    res_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      if (picks_due.size() == 0) begin
        $error("unexpected pick: out_pixel %h frame_last %b",
               res_ch.out_pixel, res_ch.frame_last);
        fail_cnt++;
      end else begin
        want = picks_due.pop_front();
        if (res_ch.out_pixel !== want.out_pixel) begin
          $error("out_pixel mismatch: expected %h, actual %h",
                 want.out_pixel, res_ch.out_pixel);
          fail_cnt++;
        end
        if (res_ch.frame_last !== want.frame_last) begin
          $error("frame_last mismatch: expected %b, actual %b",
                 want.frame_last, res_ch.frame_last);
          fail_cnt++;
        end
      end
      picks_checked++;
      if (res_ch.frame_last === 1'b1) frames_closed++;
    end
  end

  // hang detection: any transfer on either side restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("run stalled after %0d source pixels, %0d picks checked",
               pixels_sent, picks_checked);
      $display("nearest_neighbor_fit_downscale_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // 640 x 480 to 256 wide after reset: step 2.5, picks at columns 0, 2, 5, 7
  task automatic test_reset_defaults();
    logic [nnfd_pkg::PIX_W-1:0] pattern [8];
    pattern = '{32'h0000_0000, 32'h1357_9BDF, 32'hFFFF_FFFF, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h8000_0001, 32'h0000_0001, 32'hA5A5_A5A5};
    foreach (pattern[i]) send_pixel(pattern[i]);
  endtask

  // three channels switched in mid-row; the next pick (column 10) loses its top byte
  task automatic test_channel_mask_midframe();
    wait_idle();
    write_reg(nnfd_pkg::REG_CHANNELS, 13'd3);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
  endtask

  // zero width: no picks and all counters cleared on each pixel
  task automatic test_invalid_geometry();
    set_geometry(13'd0, 13'd480, 13'd256, 13'd4);
    repeat (3) send_pixel($urandom);
  endtask

  // target larger than the larger source side: empty output, counters still run
  task automatic test_upscale_request();
    set_geometry(13'd3, 13'd2, 13'd5, 13'd4);
    repeat (6) send_pixel($urandom);
  endtask

  // 4 x 1 to 2 wide rounds the height down to zero: nothing comes out
  task automatic test_degenerate_side();
    set_geometry(13'd4, 13'd1, 13'd2, 13'd3);
    repeat (4) send_pixel($urandom);
  endtask

  // 1 x 1 frames: every pixel is a whole scaled image and closes it
  task automatic test_unit_frames();
    set_geometry(13'd1, 13'd1, 13'd1, 13'd4);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
  endtask

  // random phases: mostly whole small frames, plus upscale, bad geometry, thin
  // images and short runs into the largest sizes; partial frames leave the next
  // setting to start in mid-frame
  task automatic test_random_frames(input int unsigned budget);
    int unsigned                w, h, m, big, kind, n_px, phase, stop_at, sel;
    logic [nnfd_pkg::CFG_W-1:0] ch_word;
    logic [nnfd_pkg::PIX_W-1:0] px;
    stop_at = pixels_sent + budget;
    phase   = 0;
    while (pixels_sent < stop_at) begin
      kind = (phase < 3) ? 8 : $urandom_range(0, 9);
      w    = $urandom_range(1, 16);
      h    = $urandom_range(1, 16);
      big  = (w > h) ? w : h;
      m    = $urandom_range(1, big);
      n_px = w * h * $urandom_range(1, 3);
      case (kind)
        6: begin
          // upscale request, sometimes the largest register value
          m    = ($urandom_range(0, 3) == 0) ? 8191 : big + $urandom_range(1, 8);
          n_px = w * h;
        end
        7: begin
          sel = $urandom_range(0, 4);
          case (sel)
            0: w = 0;
            1: h = 0;
            2: m = 0;
            3: w = $urandom_range(MAX_DIM + 1, 8191);
            default: h = $urandom_range(MAX_DIM + 1, 8191);
          endcase
          n_px = $urandom_range(1, 10);
        end
        8: begin
          // largest sizes, only the first few pixels of the frame
          sel = (phase < 3) ? phase : $urandom_range(0, 4);
          case (sel)
            0: begin w = MAX_DIM; h = MAX_DIM; m = 1;       end
            1: begin w = MAX_DIM; h = 1;       m = MAX_DIM; end
            2: begin w = 1;       h = MAX_DIM; m = MAX_DIM; end
            3: begin
              w = $urandom_range(1, MAX_DIM);
              h = $urandom_range(1, MAX_DIM);
              m = $urandom_range(1, MAX_DIM);
            end
            default: begin
              w = MAX_DIM;
              h = $urandom_range(1, MAX_DIM);
              m = $urandom_range(1, 64);
            end
          endcase
          n_px = $urandom_range(1, 40);
        end
        9: begin
          // one to three columns, tall
          w    = $urandom_range(1, 3);
          h    = $urandom_range(1, 40);
          big  = (w > h) ? w : h;
          m    = $urandom_range(1, big);
          n_px = w * h * $urandom_range(1, 2);
        end
        default: begin
          if ($urandom_range(0, 3) == 0) n_px = $urandom_range(1, n_px);
        end
      endcase

      // keep the total close to the pixel budget
      if (n_px > stop_at - pixels_sent) n_px = stop_at - pixels_sent;

      // channel word with junk in the unused upper bits
      ch_word = $urandom_range(0, 8191);
      case ($urandom_range(0, 3))
        0: ch_word[nnfd_pkg::CH_W-1:0] = nnfd_pkg::CH_FULL;
        1: ch_word[nnfd_pkg::CH_W-1:0] = 3'd3;
        default: ;
      endcase
      set_geometry(w[nnfd_pkg::CFG_W-1:0], h[nnfd_pkg::CFG_W-1:0],
                   m[nnfd_pkg::CFG_W-1:0], ch_word);

      // some phases run without any idling on one or both sides
      idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 16;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 16;

      repeat (n_px) begin
        px = $urandom;
        case ($urandom_range(0, 7))
          0: px = '0;
          1: px = '1;
          default: ;
        endcase
        send_pixel(px);
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = nnfd_pkg::REG_SRC_WIDTH;
    cfg_data         = '0;
    src_ch.valid     = 1'b0;
    src_ch.src_pixel = '0;

    cfg_w   = nnfd_pkg::SRC_WIDTH_RST;
    cfg_h   = nnfd_pkg::SRC_HEIGHT_RST;
    cfg_max = nnfd_pkg::MAX_SIZE_RST;
    cfg_ch  = nnfd_pkg::CHANNELS_RST;
    clear_scaler();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_channel_mask_midframe();
    test_invalid_geometry();
    test_upscale_request();
    test_degenerate_side();
    test_unit_frames();
    test_random_frames(1050 - pixels_sent);

    // all picks in, then a short quiet window to catch stray transfers
    wait_idle();
    repeat (16) @(posedge clk_i);

    $display("run covered %0d source pixels across %0d register settings",
             pixels_sent, settings_used);
    $display("%0d picks checked, %0d scaled frames closed, %0d mismatches",
             picks_checked, frames_closed, fail_cnt);
    if (fail_cnt == 0) begin
      $display("nearest_neighbor_fit_downscale_unit verification clean");
    end else begin
      $display("nearest_neighbor_fit_downscale_unit verification failed");
    end
    $finish;
  end

endmodule

[nearest_neighbor_fit_downscale_unit.f]
rtl/nnfd_pkg.sv
rtl/nnfd_src_if.sv
rtl/nnfd_res_if.sv
rtl/nnfd_div.sv
rtl/nnfd_skid.sv
rtl/nearest_neighbor_fit_downscale_unit.sv
tb/sv/tb_nearest_neighbor_fit_downscale_unit.sv
